// ----- hw/rtl/sapq_pkg.sv -----
// ============================================================================
// sapq_pkg
// Shared types and constants of the sorted array priority queue.
// ============================================================================
package sapq_pkg;

    localparam int CAPACITY = 8;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic       FN_INSERT    = 1'b0;
    localparam logic       FN_DELETE    = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DELETED   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [1:0]              status;
    } t_out_item;

endpackage

// ----- hw/rtl/sorted_array_priority_queue_core.sv -----
// ============================================================================
// sorted_array_priority_queue_core
// Fixed-capacity priority queue kept as a descending sorted array in a small
// memory, walked one slot at a time by a sequencer around a single comparator.
// ============================================================================
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | input     | i_in_valid  / o_in_stall    | i_in_data  (func, key_in)
//  out     | output    | o_out_valid / i_out_stall   | o_out_data (key_out, status)
//
//  An insert walks from the tail toward the head, shifting each stored key
//  that is less than or equal to the new key down one slot, then writes the
//  new key into the freed slot; a delete walks every stored key, capturing
//  the head and moving the rest up; overflow and underflow go straight to
//  the result. Each slot visit is a registered read of the slot memory, then a use.
//  Reset clears occupancy, the sequencer and output valid; slot contents stay.
//  o_in_stall is high whenever an operation is in progress. A finished
//  result sits in the output register while the next operation is accepted.
//
module sorted_array_priority_queue_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  sapq_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output sapq_pkg::t_out_item  o_out_data
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_IRD  = 3'd1;   // insert: read slot above pos
    localparam logic [2:0] S_ICMP = 3'd2;   // insert: compare and shift down
    localparam logic [2:0] S_DRD  = 3'd3;   // delete: read slot pos
    localparam logic [2:0] S_DMOV = 3'd4;   // delete: capture head or move up
    localparam logic [2:0] S_DONE = 3'd5;   // hand result to output register

    logic [2:0]                       r_state, n_state;
    logic [sapq_pkg::CNT_W-1:0]       r_occ, n_occ;
    logic [sapq_pkg::CNT_W-1:0]       r_pos, n_pos;
    logic signed [sapq_pkg::KEY_W-1:0] r_key, n_key;
    logic signed [sapq_pkg::KEY_W-1:0] r_key_out, n_key_out;
    logic [1:0]                       r_status, n_status;

    logic                             r_out_valid;
    sapq_pkg::t_out_item              r_out_data;

    // slot memory, one write and one registered read per cycle
    logic signed [sapq_pkg::KEY_W-1:0] r_mem [sapq_pkg::CAPACITY];
    logic signed [sapq_pkg::KEY_W-1:0] r_rd_data;
    logic [sapq_pkg::CNT_W-1:0]       w_rd_cnt;
    logic [sapq_pkg::CNT_W-1:0]       w_wr_cnt;
    logic [sapq_pkg::IDX_W-1:0]       w_rd_addr;
    logic [sapq_pkg::IDX_W-1:0]       w_wr_addr;
    logic                             w_wr_en;
    logic signed [sapq_pkg::KEY_W-1:0] w_wr_data;

    logic                             w_le;
    logic                             w_accept;
    logic                             w_out_free;

    sapq_cmp u_cmp (
        .i_a  (r_rd_data),
        .i_b  (r_key),
        .o_le (w_le)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // pos never reaches CAPACITY while it addresses a slot
    assign w_rd_addr = w_rd_cnt[sapq_pkg::IDX_W-1:0];
    assign w_wr_addr = w_wr_cnt[sapq_pkg::IDX_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_pos     = r_pos;
        n_key     = r_key;
        n_key_out = r_key_out;
        n_status  = r_status;
        w_rd_cnt  = r_pos;
        w_wr_cnt  = r_pos;
        w_wr_en   = 1'b0;
        w_wr_data = r_key;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_key     = i_in_data.key_in;
                    n_key_out = '0;
                    if (i_in_data.func == sapq_pkg::FN_INSERT) begin
                        if (r_occ >= sapq_pkg::CNT_W'(sapq_pkg::CAPACITY)) begin
                            n_status = sapq_pkg::ST_OVERFLOW;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = r_occ;
                            n_state = S_IRD;
                        end
                    end else begin
                        if (r_occ == '0) begin
                            n_status = sapq_pkg::ST_UNDERFLOW;
                            n_state  = S_DONE;
                        end else begin
                            n_pos   = '0;
                            n_state = S_DRD;
                        end
                    end
                end
            end
            S_IRD: begin
                if (r_pos == '0) begin
                    // reached the head: drop the key in slot 0
                    w_wr_en  = 1'b1;
                    n_occ    = r_occ + 1'b1;
                    n_status = sapq_pkg::ST_INSERTED;
                    n_state  = S_DONE;
                end else begin
                    w_rd_cnt = r_pos - 1'b1;
                    n_state  = S_ICMP;
                end
            end
            S_ICMP: begin
                w_wr_en = 1'b1;
                if (w_le) begin
                    // shift the smaller-or-equal key down one slot
                    w_wr_data = r_rd_data;
                    n_pos     = r_pos - 1'b1;
                    n_state   = S_IRD;
                end else begin
                    n_occ    = r_occ + 1'b1;
                    n_status = sapq_pkg::ST_INSERTED;
                    n_state  = S_DONE;
                end
            end
            S_DRD: begin
                n_state = S_DMOV;
            end
            S_DMOV: begin
                if (r_pos == '0) begin
                    n_key_out = r_rd_data;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_cnt  = r_pos - 1'b1;
                    w_wr_data = r_rd_data;
                end
                if ((r_pos + 1'b1) < r_occ) begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_DRD;
                end else begin
                    n_occ    = r_occ - 1'b1;
                    n_status = sapq_pkg::ST_DELETED;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_key_out <= n_key_out;
        r_status  <= n_status;
        if (r_state == S_DONE && w_out_free) begin
            r_out_data.key_out <= r_key_out;
            r_out_data.status  <= r_status;
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

endmodule

// ----- hw/rtl/sapq_cmp.sv -----
// ============================================================================
// sapq_cmp
// Single signed key comparator used on each insert compare step.
// ============================================================================
module sapq_cmp (
    input  logic signed [sapq_pkg::KEY_W-1:0] i_a,
    input  logic signed [sapq_pkg::KEY_W-1:0] i_b,
    output logic                              o_le
);

    // true when the stored key must move down behind the new key
    assign o_le = (i_a <= i_b);

endmodule

// ----- dv/sorted_array_priority_queue_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// sorted_array_priority_queue_core_tb
// Self-checking bench for the sorted array priority queue: a scoreboard keeps
// its own descending key list, predicts the status and key of every accepted
// transaction and checks each result in order, under random idling and stall.
// ============================================================================
module sorted_array_priority_queue_core_tb;

    import sapq_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the queue contents plus the list of results that
    // are still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class sapq_scoreboard;
        logic signed [KEY_W-1:0] queued_keys[$];   // descending, slot 0 first
        t_out_item               owed_results[$];
        int                      mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Work out the result of one accepted operation and update the mirror.
        function void note_input(t_in_item item);
            t_out_item               res;
            logic signed [KEY_W-1:0] key;
            int                      pos;
            key         = item.key_in;
            res.key_out = '0;
            if (item.func == FN_INSERT) begin
                if (queued_keys.size() >= CAPACITY) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    // newest goes ahead of every key less than or equal to it
                    pos = 0;
                    while (pos < queued_keys.size() && queued_keys[pos] > key)
                        pos++;
                    queued_keys.insert(pos, key);
                    res.status = ST_INSERTED;
                end
            end else if (queued_keys.size() == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.key_out = queued_keys.pop_front();
                res.status  = ST_DELETED;
            end
            owed_results.push_back(res);
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(input t_out_item got);
            t_out_item exp;
            if (owed_results.size() == 0) begin
                report($sformatf("result with nothing owed: key %0d status %0d",
                                 got.key_out, got.status));
            end else begin
                exp = owed_results.pop_front();
                if (got.status !== exp.status)
                    report($sformatf("status got %0d exp %0d", got.status, exp.status));
                if (got.key_out !== exp.key_out)
                    report($sformatf("key_out got %0d exp %0d",
                                     got.key_out, exp.key_out));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block I/O. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_data   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_data;

    sapq_scoreboard sb = new();

    // Idling knobs, in percent of cycles, and the receiver hold-off request.
    int tx_idle_pct    = 10;
    int rx_stall_pct   = 52;
    int rx_hold_cycles = 0;

    sorted_array_priority_queue_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit: far beyond the slowest legal run (every delete on a full
    // queue, every result waiting out heavy stall, plus the long hold-off).
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, before the block's
    // own registers update, so the sampled values are the pre-edge ones.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall each cycle, or hold stall high for a requested
    // number of cycles so the output register fills and the input backs up.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_out_stall    <= 1'b1;
                rx_hold_cycles  = rx_hold_cycles - 1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(input logic func,
                                           input logic signed [KEY_W-1:0] key);
        t_in_item item;
        item.func   = func;
        item.key_in = key;
        return item;
    endfunction

    // Key shapes: full range, a narrow band that forces equal keys, the
    // extremes and their neighbors, or a mix of all three.
    function automatic logic signed [KEY_W-1:0] next_key(input int shape);
        int pick;
        pick = (shape == 3) ? $urandom_range(0, 2) : shape;
        case (pick)
            0: return $urandom;
            1: return $signed($urandom_range(0, 6)) - 3;
            default: begin
                case ($urandom_range(0, 6))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh7FFF_FFFE;
                    2: return 32'sh8000_0000;
                    3: return 32'sh8000_0001;
                    4: return 32'sh0000_0000;
                    5: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    // Offer one transaction and hold it until the block takes it. Valid stays
    // high on return so back-to-back items need no extra edge.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic send_op(input logic func, input logic signed [KEY_W-1:0] key);
        send_item(make_item(func, key));
    endtask

    // Pause the sender until every owed result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Random traffic in bursts: each burst leans toward inserts, deletes or
    // neither, so the queue swings between empty and full and hits both
    // overflow and underflow often.
    task automatic run_random(input int n_items);
        int done;
        int burst;
        int ins_pct;
        int shape;
        done = 0;
        while (done < n_items) begin
            burst = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       ins_pct = 25;
                1:       ins_pct = 50;
                default: ins_pct = 80;
            endcase
            shape = $urandom_range(0, 3);
            for (int i = 0; i < burst && done < n_items; i++) begin
                send_op(($urandom_range(0, 99) < ins_pct) ? FN_INSERT : FN_DELETE,
                        next_key(shape));
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: underflow on empty (key ignored), fill with extremes and
        // duplicates, overflow twice, drain in order, underflow again, then
        // equal keys mixed with the minimum.
        send_op(FN_DELETE, 32'sh7FFF_FFFF);
        send_op(FN_INSERT, 32'sh7FFF_FFFF);
        send_op(FN_INSERT, 32'sh8000_0000);
        send_op(FN_INSERT, 32'sd0);
        send_op(FN_INSERT, -32'sd1);
        send_op(FN_INSERT, 32'sd1);
        send_op(FN_INSERT, 32'sd5);
        send_op(FN_INSERT, 32'sd5);
        send_op(FN_INSERT, -32'sd5);
        send_op(FN_INSERT, 32'sd123);
        send_op(FN_INSERT, 32'sh8000_0000);
        for (int i = 0; i < CAPACITY; i++)
            send_op(FN_DELETE, -32'sd1);
        send_op(FN_DELETE, 32'sd0);
        send_op(FN_INSERT, -32'sd1);
        send_op(FN_INSERT, -32'sd1);
        send_op(FN_INSERT, 32'sh8000_0000);
        send_op(FN_DELETE, 32'sh5555_5555);
        send_op(FN_DELETE, 32'shAAAA_AAAA);
        send_op(FN_DELETE, 32'sd0);

        // Phase one: light sender idling, heavy receiver stall. Part way
        // through, hold the receiver off long enough for the input to back up
        // while the sender keeps offering.
        drain_results();
        run_random(150);
        rx_hold_cycles = 400;
        run_random(317);

        // Phase two: swap the idling roles.
        drain_results();
        tx_idle_pct  = 52;
        rx_stall_pct = 10;
        run_random(467);

        // Phase three: full rate on both sides.
        drain_results();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(466);

        // Wind down: wait for every owed result, then keep running so
        // any stray output would still be caught.
        drain_results();
        repeat (4 * (2 * CAPACITY + 3))
            @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
